### hdl/otap_pkg.sv
// ----------------------------------------------------------------------------
// otap_pkg: shared types and constants of the upgrade image parser
// Phase codes, result kinds, verdict codes and the front-to-back record.
// ----------------------------------------------------------------------------
package otap_pkg;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_FIELDS = 3'd1,
    PH_SKIP   = 3'd2,
    PH_EHDR   = 3'd3,
    PH_EDATA  = 3'd4,
    PH_DRAIN  = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_FIELD   = 2'd0;
  localparam logic [1:0] KIND_START   = 2'd1;
  localparam logic [1:0] KIND_DATA    = 2'd2;
  localparam logic [1:0] KIND_VERDICT = 2'd3;

  localparam logic [2:0] VD_OK       = 3'd0;
  localparam logic [2:0] VD_SHORT    = 3'd1;
  localparam logic [2:0] VD_NO_MAGIC = 3'd2;
  localparam logic [2:0] VD_HDR_LEN  = 3'd3;
  localparam logic [2:0] VD_NO_ELEM  = 3'd4;
  localparam logic [2:0] VD_IN_HDR   = 3'd5;

  localparam logic [3:0] FLD_HDR_LEN = 4'd2;
  localparam logic [3:0] FLD_CONTROL = 4'd3;
  localparam logic [3:0] FLD_STRING  = 4'd8;
  localparam logic [3:0] FLD_DONE    = 4'd14;

  localparam logic [31:0] MAGIC     = 32'h1EF1EE0B;
  localparam logic [15:0] MAND_LEN  = 16'd56;
  localparam logic [3:0]  EHDR_LEN  = 4'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  field_id;
    logic [4:0]  string_index;
    logic [63:0] value;
    logic [15:0] tag;
    logic        element_end;
    logic        cut_short;
    logic [2:0]  verdict;
    logic        run_last;
  } result_t;

  // one decoded input byte: up to two results
  typedef struct packed {
    logic    has0;
    result_t r0;
    logic    has1;
    result_t r1;
  } pair_t;

  function automatic logic [3:0] field_len(input logic [3:0] f);
    case (f)
      4'd0, 4'd6, 4'd9: field_len = 4'd4;
      4'd8, 4'd10:      field_len = 4'd1;
      4'd11:            field_len = 4'd8;
      4'd14, 4'd15:     field_len = 4'd1;
      default:          field_len = 4'd2;
    endcase
  endfunction

  function automatic logic [3:0] next_field(input logic [3:0] f, input logic [15:0] done,
                                           input logic [15:0] ctl);
    if (f < 4'd7) next_field = f + 4'd1;
    else if (f == 4'd7) next_field = FLD_STRING;
    else if (f == FLD_STRING) next_field = (done < 16'd52) ? FLD_STRING : 4'd9;
    else if (f == 4'd9 && ctl[0]) next_field = 4'd10;
    else if (f <= 4'd10 && ctl[1]) next_field = 4'd11;
    else if (f <= 4'd11 && ctl[2]) next_field = 4'd12;
    else if (f == 4'd12) next_field = 4'd13;
    else next_field = FLD_DONE;
  endfunction

endpackage

### hdl/otap_front.sv
// ----------------------------------------------------------------------------
// otap_front: byte decoder
// Runs the parse state per accepted byte and forms up to two results.
// ----------------------------------------------------------------------------
module otap_front #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            in_fin,
  output logic            in_ready,
  output otap_pkg::pair_t pair,
  output logic            pair_valid,
  input  logic            pair_ready
);

  otap_pkg::phase_t phase, phase_next;
  logic [23:0] magic_window, magic_window_next;
  logic [COUNT_WIDTH-1:0] bytes_seen, bytes_seen_next;
  logic [63:0] field_shift, field_shift_next;
  logic [3:0]  field_byte_index, field_byte_index_next;
  logic [3:0]  current_field, current_field_next;
  logic [15:0] declared_header_length, declared_header_length_next;
  logic [15:0] control_bits, control_bits_next;
  logic [15:0] header_bytes_done, header_bytes_done_next;
  logic [47:0] element_header_shift, element_header_shift_next;
  logic [31:0] element_remaining, element_remaining_next;
  logic [15:0] current_tag, current_tag_next;
  logic        any_element, any_element_next;
  otap_pkg::pair_t pair_next;
  logic        fire;

  assign in_ready = pair_ready;
  assign fire     = in_valid & in_ready;
  assign pair_valid = fire;
  assign pair = pair_next;

  always_comb begin
    logic [31:0] w;
    logic [63:0] fs;
    logic [47:0] es;
    logic [3:0]  fbi;
    logic [3:0]  nf;
    logic [15:0] hbd;
    logic [31:0] rem;
    logic        done;
    otap_pkg::result_t r;
    otap_pkg::phase_t  ph_end;
    logic [2:0]  vd;
    phase_next = phase;
    magic_window_next = magic_window;
    bytes_seen_next = (bytes_seen != '1) ? bytes_seen + 1'b1 : bytes_seen;
    field_shift_next = field_shift;
    field_byte_index_next = field_byte_index;
    current_field_next = current_field;
    declared_header_length_next = declared_header_length;
    control_bits_next = control_bits;
    header_bytes_done_next = header_bytes_done;
    element_header_shift_next = element_header_shift;
    element_remaining_next = element_remaining;
    current_tag_next = current_tag;
    any_element_next = any_element;
    r = '0;
    pair_next = '0;
    w = {magic_window, in_byte};
    fs = field_shift | ({56'd0, in_byte} << {field_byte_index[2:0], 3'b000});
    es = element_header_shift | ({40'd0, in_byte} << {field_byte_index[2:0], 3'b000});
    fbi = field_byte_index + 4'd1;
    hbd = header_bytes_done + 16'd1;
    rem = element_remaining - 32'd1;
    done = (rem == 32'd0);
    nf = '0;
    case (phase)
      otap_pkg::PH_SEARCH: begin
        magic_window_next = w[23:0];
        if (w == otap_pkg::MAGIC) begin
          r.kind = otap_pkg::KIND_FIELD;
          r.value = 64'h0BEEF11E;
          pair_next.has0 = 1'b1;
          phase_next = otap_pkg::PH_FIELDS;
          header_bytes_done_next = 16'd4;
          current_field_next = 4'd1;
          field_byte_index_next = '0;
          field_shift_next = '0;
        end
      end
      otap_pkg::PH_FIELDS: begin
        field_shift_next = fs;
        header_bytes_done_next = hbd;
        field_byte_index_next = fbi;
        if (fbi >= otap_pkg::field_len(current_field)) begin
          r.kind = otap_pkg::KIND_FIELD;
          r.field_id = current_field;
          r.string_index = (current_field == otap_pkg::FLD_STRING) ?
                           5'(header_bytes_done - 16'd20) : 5'd0;
          r.value = fs;
          pair_next.has0 = 1'b1;
          field_shift_next = '0;
          field_byte_index_next = '0;
          if (current_field == otap_pkg::FLD_CONTROL) control_bits_next = fs[15:0];
          if (current_field == otap_pkg::FLD_HDR_LEN) begin
            declared_header_length_next = fs[15:0];
          end
          if (current_field == otap_pkg::FLD_HDR_LEN && fs[15:0] < otap_pkg::MAND_LEN) begin
            phase_next = otap_pkg::PH_DRAIN;
          end else begin
            nf = otap_pkg::next_field(current_field, hbd,
                   (current_field == otap_pkg::FLD_CONTROL) ? fs[15:0] : control_bits);
            if (nf >= otap_pkg::FLD_DONE) begin
              phase_next = (hbd < declared_header_length_next) ? otap_pkg::PH_SKIP
                                                               : otap_pkg::PH_EHDR;
            end else begin
              current_field_next = nf;
            end
          end
        end
      end
      otap_pkg::PH_SKIP: begin
        header_bytes_done_next = hbd;
        if (hbd >= declared_header_length) phase_next = otap_pkg::PH_EHDR;
      end
      otap_pkg::PH_EHDR: begin
        element_header_shift_next = es;
        field_byte_index_next = fbi;
        if (fbi >= otap_pkg::EHDR_LEN) begin
          current_tag_next = es[15:0];
          element_remaining_next = es[47:16];
          element_header_shift_next = '0;
          field_byte_index_next = '0;
          any_element_next = 1'b1;
          r.kind = otap_pkg::KIND_START;
          r.value = {32'd0, es[47:16]};
          r.tag = es[15:0];
          pair_next.has0 = 1'b1;
          if (es[47:16] == 32'd0) begin
            r.element_end = 1'b1;
          end else begin
            r.element_end = in_fin;
            r.cut_short = in_fin;
            phase_next = otap_pkg::PH_EDATA;
          end
        end
      end
      otap_pkg::PH_EDATA: begin
        element_remaining_next = rem;
        r.kind = otap_pkg::KIND_DATA;
        r.value = {56'd0, in_byte};
        r.tag = current_tag;
        r.element_end = done | in_fin;
        r.cut_short = in_fin & ~done;
        pair_next.has0 = 1'b1;
        if (done) begin
          phase_next = otap_pkg::PH_EHDR;
          field_byte_index_next = '0;
          element_header_shift_next = '0;
        end
      end
      default: phase_next = otap_pkg::PH_DRAIN;
    endcase
    ph_end = phase_next;
    if (bytes_seen_next < COUNT_WIDTH'(otap_pkg::MAND_LEN)) vd = otap_pkg::VD_SHORT;
    else if (ph_end == otap_pkg::PH_SEARCH) vd = otap_pkg::VD_NO_MAGIC;
    else if (ph_end == otap_pkg::PH_FIELDS || ph_end == otap_pkg::PH_SKIP)
      vd = otap_pkg::VD_IN_HDR;
    else if (ph_end == otap_pkg::PH_EHDR || ph_end == otap_pkg::PH_EDATA)
      vd = any_element_next ? otap_pkg::VD_OK : otap_pkg::VD_NO_ELEM;
    else vd = otap_pkg::VD_HDR_LEN;
    pair_next.r0 = r;
    if (in_fin) begin
      pair_next.has1 = pair_next.has0;
      pair_next.r1 = '0;
      pair_next.r1.kind = otap_pkg::KIND_VERDICT;
      pair_next.r1.verdict = vd;
      pair_next.r1.run_last = 1'b1;
      if (!pair_next.has0) begin
        pair_next.has0 = 1'b1;
        pair_next.r0 = pair_next.r1;
        pair_next.has1 = 1'b0;
      end
    end else begin
      pair_next.r0.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && in_fin)) begin
      phase <= otap_pkg::PH_SEARCH;
      magic_window <= '0;
      bytes_seen <= '0;
      field_shift <= '0;
      field_byte_index <= '0;
      current_field <= '0;
      declared_header_length <= '0;
      control_bits <= '0;
      header_bytes_done <= '0;
      element_header_shift <= '0;
      element_remaining <= '0;
      current_tag <= '0;
      any_element <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
      magic_window <= magic_window_next;
      bytes_seen <= bytes_seen_next;
      field_shift <= field_shift_next;
      field_byte_index <= field_byte_index_next;
      current_field <= current_field_next;
      declared_header_length <= declared_header_length_next;
      control_bits <= control_bits_next;
      header_bytes_done <= header_bytes_done_next;
      element_header_shift <= element_header_shift_next;
      element_remaining <= element_remaining_next;
      current_tag <= current_tag_next;
      any_element <= any_element_next;
    end
  end

endmodule

### hdl/otap_queue.sv
// ----------------------------------------------------------------------------
// otap_queue: result queue
// Takes one or two results per cycle if two are free; one out per res_ready.
// ----------------------------------------------------------------------------
module otap_queue (
  input  logic              clk,
  input  logic              rst,
  input  otap_pkg::pair_t   pair,
  input  logic              pair_valid,
  output logic              pair_ready,
  output otap_pkg::result_t res,
  output logic              res_valid,
  input  logic              res_ready
);

  localparam int DEPTH = 4;

  otap_pkg::result_t mem [DEPTH];
  logic [1:0] wp, rp;
  logic [2:0] count, count_next;
  logic       pop;
  logic [1:0] npush;

  assign pair_ready = (count <= 3'd2);
  assign res_valid  = (count != 3'd0);
  assign res        = mem[rp];
  assign pop        = res_valid & res_ready;
  assign npush      = (pair_valid & pair_ready) ?
                      ({1'b0, pair.has0} + {1'b0, pair.has1}) : 2'd0;
  assign count_next = count + {1'b0, npush} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      wp <= wp + npush;
      if (pop) rp <= rp + 2'd1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_valid && pair_ready) begin
      if (pair.has0) mem[wp] <= pair.r0;
      if (pair.has1) mem[wp + 2'd1] <= pair.r1;
    end
  end

endmodule

### hdl/ota_image_stream_parser.sv
// ----------------------------------------------------------------------------
// ota_image_stream_parser: upgrade image stream parser
// Finds the image magic, decodes header fields and emits sub-elements.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one file byte per beat; tlast marks the last byte.
//   m_axis carries one result per beat (header field, sub-element start,
//   sub-element data byte, or file verdict); tlast marks the last result
//   caused by one input byte.
//   One byte is taken per cycle while s_axis_tready is high; its results
//   are registered in the queue. A byte causes at most two results; the
//   four-entry queue drains one per cycle while m_axis_tready is high.
//   When m_axis stalls, the queue fills and s_axis_tready drops once fewer
//   than two entries are free.
//   Reset clears the parse state and empties the queue; the first byte
//   after reset or after a verdict starts a new file.
//   COUNT_WIDTH sets the saturating byte counter width.
// ----------------------------------------------------------------------------
module ota_image_stream_parser #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // final_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] kind, [5:2] field_id, [10:6] string_index, [74:11] value,
  // [90:75] tag, [91] element_end, [92] cut_short, [95:93] verdict
  output logic [95:0]  m_axis_tdata,
  output logic         m_axis_tlast    // run_last
);

  otap_pkg::pair_t   pair;
  logic              pair_valid, pair_ready;
  otap_pkg::result_t res;

  otap_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_byte(s_axis_tdata), .in_fin(s_axis_tlast),
    .in_ready(s_axis_tready),
    .pair, .pair_valid, .pair_ready
  );

  otap_queue u_queue (
    .clk, .rst, .pair, .pair_valid, .pair_ready,
    .res, .res_valid(m_axis_tvalid), .res_ready(m_axis_tready)
  );

  assign m_axis_tdata = {res.verdict, res.cut_short, res.element_end, res.tag, res.value,
                         res.string_index, res.field_id, res.kind};
  assign m_axis_tlast = res.run_last;

  a_cut_ends: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[92] |-> m_axis_tdata[91])
    else $error("cut_short without element_end");

  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] == otap_pkg::KIND_VERDICT |-> m_axis_tlast)
    else $error("verdict not last of run");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("m_axis beat changed while stalled");

endmodule

### tb/sv/ota_image_stream_parser_test.sv
// ----------------------------------------------------------------------------
// ota_image_stream_parser_test: self-checking bench for the image parser
// Streams whole image files byte by byte (valid files, truncated files, bad
// header lengths, short files and noise), predicts every result beat from a
// behavioral parser and compares each field of every m_axis beat in order.
// ----------------------------------------------------------------------------
module ota_image_stream_parser_test;

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         hold;
  } in_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tlast;

  in_beat_t byte_queue[$];
  in_beat_t next_beat;
  otap_pkg::result_t due_results[$];
  int       total_bytes = 0;
  int       bytes_taken = 0;
  int       tx_idle = 0;
  int       rx_idle = 0;
  int       errors = 0;
  int       quiet_cycles = 0;
  logic     took_in = 1'b0;

  // parser state
  otap_pkg::phase_t ph;
  logic [23:0] win;
  logic [31:0] seen;
  logic [63:0] fshift;
  logic [3:0]  fidx;
  logic [3:0]  cur_field;
  logic [15:0] hdr_len;
  logic [15:0] ctl_bits;
  logic [15:0] hdr_done;
  logic [47:0] eshift;
  logic [31:0] remaining;
  logic [15:0] cur_tag;
  logic        any_elem;

  ota_image_stream_parser dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic clear_parser();
    ph = otap_pkg::PH_SEARCH;
    win = '0;
    seen = '0;
    fshift = '0;
    fidx = '0;
    cur_field = '0;
    hdr_len = '0;
    ctl_bits = '0;
    hdr_done = '0;
    eshift = '0;
    remaining = '0;
    cur_tag = '0;
    any_elem = 1'b0;
  endtask

  function automatic logic [3:0] field_bytes(input logic [3:0] f);
    case (f)
      4'd0, 4'd6, 4'd9: return 4'd4;
      4'd11:            return 4'd8;
      4'd8, 4'd10, 4'd14, 4'd15: return 4'd1;
      default:          return 4'd2;
    endcase
  endfunction

  function automatic otap_pkg::result_t mk(input logic [1:0] kind, input logic [3:0] fid,
                                           input logic [4:0] sidx, input logic [63:0] val,
                                           input logic [15:0] tag, input logic fend,
                                           input logic cut, input logic [2:0] vd);
    otap_pkg::result_t r;
    r.kind = kind;
    r.field_id = fid;
    r.string_index = sidx;
    r.value = val;
    r.tag = tag;
    r.element_end = fend;
    r.cut_short = cut;
    r.verdict = vd;
    r.run_last = 1'b0;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    otap_pkg::result_t got[$];
    logic [3:0]  cf;
    logic [3:0]  nf;
    logic [4:0]  sidx;
    logic [63:0] v;
    logic [31:0] len;
    logic [2:0]  vd;
    if (seen != '1) seen++;
    case (ph)
      otap_pkg::PH_SEARCH: begin
        if ({win, b} == otap_pkg::MAGIC) begin
          got = {got, mk(otap_pkg::KIND_FIELD, 4'd0, 5'd0, 64'h0BEE_F11E, 16'd0, 1'b0,
                         1'b0, otap_pkg::VD_OK)};
          ph = otap_pkg::PH_FIELDS;
          hdr_done = 16'd4;
          cur_field = 4'd1;
          fidx = '0;
          fshift = '0;
        end
        win = {win[15:0], b};
      end
      otap_pkg::PH_FIELDS: begin
        cf = cur_field;
        sidx = (cf == otap_pkg::FLD_STRING) ? 5'(hdr_done - 16'd20) : 5'd0;
        fshift |= 64'(b) << (8 * fidx[2:0]);
        hdr_done++;
        fidx++;
        if (fidx >= field_bytes(cf)) begin
          v = fshift;
          got = {got, mk(otap_pkg::KIND_FIELD, cf, sidx, v, 16'd0, 1'b0, 1'b0,
                         otap_pkg::VD_OK)};
          fshift = '0;
          fidx = '0;
          if (cf == otap_pkg::FLD_CONTROL) ctl_bits = v[15:0];
          if (cf == otap_pkg::FLD_HDR_LEN) begin
            hdr_len = v[15:0];
            if (hdr_len < otap_pkg::MAND_LEN) ph = otap_pkg::PH_DRAIN;
          end
          if (ph == otap_pkg::PH_FIELDS) begin
            if (cf < 4'd7) nf = cf + 4'd1;
            else if (cf == 4'd7) nf = otap_pkg::FLD_STRING;
            else if (cf == otap_pkg::FLD_STRING)
              nf = (hdr_done < 16'd52) ? otap_pkg::FLD_STRING : 4'd9;
            else if (cf == 4'd9 && ctl_bits[0]) nf = 4'd10;
            else if (cf <= 4'd10 && ctl_bits[1]) nf = 4'd11;
            else if (cf <= 4'd11 && ctl_bits[2]) nf = 4'd12;
            else if (cf == 4'd12) nf = 4'd13;
            else nf = otap_pkg::FLD_DONE;
            if (nf >= otap_pkg::FLD_DONE)
              ph = (hdr_done < hdr_len) ? otap_pkg::PH_SKIP : otap_pkg::PH_EHDR;
            else cur_field = nf;
          end
        end
      end
      otap_pkg::PH_SKIP: begin
        hdr_done++;
        if (hdr_done >= hdr_len) ph = otap_pkg::PH_EHDR;
      end
      otap_pkg::PH_EHDR: begin
        eshift |= 48'(b) << (8 * fidx[2:0]);
        fidx++;
        if (fidx >= otap_pkg::EHDR_LEN) begin
          len = eshift[47:16];
          cur_tag = eshift[15:0];
          remaining = len;
          eshift = '0;
          fidx = '0;
          any_elem = 1'b1;
          if (len == 0) begin
            got = {got, mk(otap_pkg::KIND_START, 4'd0, 5'd0, 64'(len), cur_tag, 1'b1, 1'b0,
                           otap_pkg::VD_OK)};
          end else begin
            got = {got, mk(otap_pkg::KIND_START, 4'd0, 5'd0, 64'(len), cur_tag, fin, fin,
                           otap_pkg::VD_OK)};
            ph = otap_pkg::PH_EDATA;
          end
        end
      end
      otap_pkg::PH_EDATA: begin
        remaining--;
        got = {got, mk(otap_pkg::KIND_DATA, 4'd0, 5'd0, 64'(b), cur_tag,
                       (remaining == 0) || fin, fin && (remaining != 0), otap_pkg::VD_OK)};
        if (remaining == 0) begin
          ph = otap_pkg::PH_EHDR;
          fidx = '0;
          eshift = '0;
        end
      end
      default: ph = otap_pkg::PH_DRAIN;
    endcase
    if (fin) begin
      if (seen < 32'(otap_pkg::MAND_LEN)) vd = otap_pkg::VD_SHORT;
      else if (ph == otap_pkg::PH_SEARCH) vd = otap_pkg::VD_NO_MAGIC;
      else if (ph == otap_pkg::PH_FIELDS || ph == otap_pkg::PH_SKIP) vd = otap_pkg::VD_IN_HDR;
      else if (ph == otap_pkg::PH_EHDR || ph == otap_pkg::PH_EDATA)
        vd = any_elem ? otap_pkg::VD_OK : otap_pkg::VD_NO_ELEM;
      else vd = otap_pkg::VD_HDR_LEN;
      got = {got, mk(otap_pkg::KIND_VERDICT, 4'd0, 5'd0, 64'd0, 16'd0, 1'b0, 1'b0, vd)};
      clear_parser();
    end
    if (got.size() > 0) got[got.size() - 1].run_last = 1'b1;
    foreach (got[i]) due_results = {due_results, got[i]};
  endtask

  task automatic report(input string what, input logic [63:0] seen_v, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h (byte %0d)", what, seen_v, want, bytes_taken);
  endtask

  task automatic add_file(input logic [7:0] f[$], input bit hold);
    in_beat_t nb;
    foreach (f[i]) begin
      nb.b = f[i];
      nb.last = (i == f.size() - 1);
      nb.hold = hold && (i == 0);
      byte_queue = {byte_queue, nb};
    end
    total_bytes += f.size();
  endtask

  // ctl: full 16-bit control word; extra < 0 puts the header length at 56
  task automatic make_file(input logic [15:0] ctl, input int extra, input int nel,
                           input bit bad_len, input int trunc, input bit hold);
    logic [7:0]  f[$];
    logic [15:0] hl;
    logic [31:0] len;
    int          opt;
    int          npre;
    int          ndata;
    opt = (ctl[0] ? 1 : 0) + (ctl[1] ? 8 : 0) + (ctl[2] ? 4 : 0);
    npre = $urandom_range(0, 3);
    repeat (npre) f = {f, 8'($urandom)};
    f = {f, otap_pkg::MAGIC[31:24]};
    f = {f, otap_pkg::MAGIC[23:16]};
    f = {f, otap_pkg::MAGIC[15:8]};
    f = {f, otap_pkg::MAGIC[7:0]};
    if (bad_len) hl = 16'($urandom_range(0, 55));
    else if (extra < 0) hl = otap_pkg::MAND_LEN;
    else hl = otap_pkg::MAND_LEN + 16'(opt + extra);
    repeat (2) f = {f, 8'($urandom)};
    f = {f, hl[7:0]};
    f = {f, hl[15:8]};
    f = {f, ctl[7:0]};
    f = {f, ctl[15:8]};
    repeat (46 + opt + (extra > 0 ? extra : 0)) f = {f, 8'($urandom)};
    for (int e = 0; e < nel; e++) begin
      f = {f, 8'($urandom)};
      f = {f, 8'($urandom)};
      if ($urandom_range(9) == 0) begin
        len = $urandom | 32'h100;
        ndata = $urandom_range(0, 4);
      end else begin
        len = (trunc != 0 && e == 0) ? $urandom_range(1, 6) : $urandom_range(0, 6);
        ndata = len;
      end
      for (int k = 0; k < 4; k++) f = {f, len[8*k +: 8]};
      repeat (ndata) f = {f, 8'($urandom)};
      if (ndata != len) break;
    end
    repeat ($urandom_range(0, 5)) f = {f, 8'($urandom)};
    if (trunc > 0) while (f.size() > npre + trunc) void'(f.pop_back());
    add_file(f, hold);
  endtask

  task automatic raw_file(input int n, input logic [7:0] fill, input bit rnd);
    logic [7:0] f[$];
    repeat (n) f = {f, (rnd ? 8'($urandom) : fill)};
    add_file(f, 1'b0);
  endtask

  initial begin
    int pick;
    clear_parser();
    // directed
    make_file(16'h0000, 0, 2, 1'b0, 0, 1'b0);
    make_file(16'hFFFF, 5, 3, 1'b0, 0, 1'b0);
    make_file(16'h0007, -1, 1, 1'b0, 0, 1'b0);
    make_file(16'h0000, 0, 1, 1'b1, 0, 1'b0);
    make_file(16'h0005, 0, 1, 1'b0, 30, 1'b1);
    make_file(16'h0000, 6, 1, 1'b0, 59, 1'b0);
    make_file(16'h0000, 0, 1, 1'b0, 62, 1'b0);
    make_file(16'h0000, 0, 1, 1'b0, 64, 1'b0);
    make_file(16'h0002, 0, 0, 1'b0, 0, 1'b0);
    raw_file(1, 8'hFF, 1'b0);
    raw_file(55, 8'h00, 1'b0);
    raw_file(70, 8'hFF, 1'b0);
    // random
    while (total_bytes < 1700) begin
      pick = $urandom_range(99);
      if (pick < 68)
        make_file(16'($urandom), $urandom_range(0, 1) ? -1 : $urandom_range(0, 6),
                  $urandom_range(0, 4), 1'b0, 0, pick < 3);
      else if (pick < 80)
        make_file(16'($urandom), $urandom_range(0, 4), $urandom_range(1, 3), 1'b0,
                  $urandom_range(1, 90), 1'b0);
      else if (pick < 86)
        make_file(16'($urandom), 0, 1, 1'b1, 0, 1'b0);
      else if (pick < 92)
        raw_file($urandom_range(1, 55), 8'd0, 1'b1);
      else
        raw_file($urandom_range(56, 90), 8'd0, 1'b1);
    end
    while (byte_queue.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (due_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // stimulus and back-pressure
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (bytes_taken < total_bytes / 3) begin
        tx_idle = 14;
        rx_idle = 81;
      end else if (bytes_taken < 2 * total_bytes / 3) begin
        tx_idle = 81;
        rx_idle = 14;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
      if (!s_axis_tvalid || took_in) begin
        if (byte_queue.size() > 0 && !(byte_queue[0].hold && due_results.size() > 0)
            && $urandom_range(99) >= tx_idle) begin
          next_beat = byte_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= next_beat.b;
          s_axis_tlast <= next_beat.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    otap_pkg::result_t e;
    if (!rst) begin
      took_in <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          report("unexpected beat", m_axis_tdata[63:0], 64'd0);
        end else begin
          e = due_results.pop_front();
          if (m_axis_tdata[1:0] != e.kind)
            report("kind", 64'(m_axis_tdata[1:0]), 64'(e.kind));
          if (m_axis_tdata[5:2] != e.field_id)
            report("field_id", 64'(m_axis_tdata[5:2]), 64'(e.field_id));
          if (m_axis_tdata[10:6] != e.string_index)
            report("string_index", 64'(m_axis_tdata[10:6]), 64'(e.string_index));
          if (m_axis_tdata[74:11] != e.value) report("value", m_axis_tdata[74:11], e.value);
          if (m_axis_tdata[90:75] != e.tag)
            report("tag", 64'(m_axis_tdata[90:75]), 64'(e.tag));
          if (m_axis_tdata[91] != e.element_end)
            report("element_end", 64'(m_axis_tdata[91]), 64'(e.element_end));
          if (m_axis_tdata[92] != e.cut_short)
            report("cut_short", 64'(m_axis_tdata[92]), 64'(e.cut_short));
          if (m_axis_tdata[95:93] != e.verdict)
            report("verdict", 64'(m_axis_tdata[95:93]), 64'(e.verdict));
          if (m_axis_tlast != e.run_last)
            report("tlast", 64'(m_axis_tlast), 64'(e.run_last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, s_axis_tlast);
        bytes_taken++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= 5000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

endmodule

### filelist.f
hdl/otap_pkg.sv
hdl/otap_front.sv
hdl/otap_queue.sv
hdl/ota_image_stream_parser.sv
tb/sv/ota_image_stream_parser_test.sv
